FILE: src/schpt_pkg.sv
`default_nettype none

package schpt_pkg;

  // Default sizing of the block
  localparam int unsigned AdcBitsDef     = 12;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned MaxSteps       = 24;
  localparam int unsigned StepIdxW       = 5;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Fixed datapath widths
  localparam int unsigned HallW   = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned AngleW  = 16;
  localparam int unsigned ZAccW   = 32;
  localparam int unsigned CordicW = 36;

  // Binary angle landmarks
  localparam logic [AngleW-1:0] QuarterTurn      = 16'h4000;
  localparam logic [AngleW-1:0] ThreeQuarterTurn = 16'hC000;
  localparam logic [ZAccW-1:0]  HalfTurnAcc      = 32'h8000_0000;
  localparam logic [ZAccW-1:0]  RoundHalf        = 32'h0000_8000;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIN_OFFSET   = 3'd0,
    CFG_COS_OFFSET   = 3'd1,
    CFG_SIN_GAIN     = 3'd2,
    CFG_COS_GAIN     = 3'd3,
    CFG_ANGLE_OFFSET = 3'd4
  } cfg_reg_e;

  // Stroke direction codes
  typedef enum logic [1:0] {
    STROKE_UNKNOWN = 2'd0,
    STROKE_DOWN    = 2'd1,
    STROKE_UP      = 2'd2
  } stroke_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_SIN,
    ST_MUL_COS,
    ST_SAT_COS,
    ST_PREP,
    ST_ITER,
    ST_DONE
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic                capture;
    logic                mul_en;
    logic                mul_cos;
    logic                sat_sin;
    logic                sat_cos;
    logic                prep;
    logic                iter;
    logic                load;
    logic [StepIdxW-1:0] step;
  } ctrl_cmd_t;

  // Arctangent of 2^-i, 32-bit binary angle per turn
  function automatic logic [ZAccW-1:0] atan_entry(input logic [StepIdxW-1:0] idx);
    logic [ZAccW-1:0] r;
    unique case (idx)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051D;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2E;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2F9;
      5'd15:   r = 32'h0000_517C;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A2F;
      5'd19:   r = 32'h0000_0517;
      5'd20:   r = 32'h0000_028B;
      5'd21:   r = 32'h0000_0145;
      5'd22:   r = 32'h0000_00A2;
      5'd23:   r = 32'h0000_0051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/sincos_hall_phase_tracker_core.sv
// Sine/cosine hall phase tracker. Each transaction carries one raw sine and
// one raw cosine ADC code; the block removes the channel offsets, applies the
// Q8.8 gains with saturation to Q1.14, takes atan2 by an iterative vectoring
// CORDIC and returns the binary angle, the phase (angle offset minus angle),
// the stroke direction and the running code range. One transaction is worked
// on at a time. The samples are captured at the accepting edge and then pass
// through the gain multiplier, shared by both channels, the saturation, the
// CORDIC set-up, the CORDIC steps and the result stage. The input is taken
// again in the cycle after the result is formed, so a new transaction is not
// accepted before the last one is through. A finished result sits in the
// output register, and the next transaction is taken while it waits; a
// further result holds in the last stage until the output register is free.
// The user must write the configuration registers only while the block is
// idle; the block itself does not enforce this.
`default_nettype none

module sincos_hall_phase_tracker_core #(
  parameter int unsigned ADC_BITS     = schpt_pkg::AdcBitsDef,
  parameter int unsigned CORDIC_STEPS = schpt_pkg::CordicStepsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [schpt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [schpt_pkg::CfgDataW-1:0]   cfg_data_i,
  // Sample input
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [ADC_BITS-1:0]              sin_sample_i,
  input  wire logic [ADC_BITS-1:0]              cos_sample_i,
  // Result output
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic signed [schpt_pkg::HallW-1:0]    hall_sin_o,
  output logic signed [schpt_pkg::HallW-1:0]    hall_cos_o,
  output logic [schpt_pkg::AngleW-1:0]          raw_angle_o,
  output logic [schpt_pkg::AngleW-1:0]          phase_o,
  output logic [1:0]                            stroke_o,
  output logic [ADC_BITS-1:0]                   sin_min_o,
  output logic [ADC_BITS-1:0]                   sin_max_o,
  output logic [ADC_BITS-1:0]                   cos_min_o,
  output logic [ADC_BITS-1:0]                   cos_max_o
);

  schpt_pkg::ctrl_cmd_t cmd;

  schpt_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  schpt_dp #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sin_sample_i (sin_sample_i),
    .cos_sample_i (cos_sample_i),
    .cmd_i        (cmd),
    .hall_sin_o   (hall_sin_o),
    .hall_cos_o   (hall_cos_o),
    .raw_angle_o  (raw_angle_o),
    .phase_o      (phase_o),
    .stroke_o     (stroke_o),
    .sin_min_o    (sin_min_o),
    .sin_max_o    (sin_max_o),
    .cos_min_o    (cos_min_o),
    .cos_max_o    (cos_max_o)
  );

endmodule

`default_nettype wire

FILE: src/schpt_ctrl.sv
`default_nettype none

module schpt_ctrl #(
  parameter int unsigned CORDIC_STEPS = schpt_pkg::CordicStepsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output schpt_pkg::ctrl_cmd_t   cmd_o
);

  localparam int unsigned CntW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CntW-1:0] LastStep = CntW'(CORDIC_STEPS - 1);

  schpt_pkg::ctrl_state_e state_q, state_d;
  logic [CntW-1:0]        step_q, step_d;
  logic                   out_valid_q, out_valid_d;
  logic                   in_acc;
  logic                   out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // State, step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= schpt_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    cmd_o.step  = schpt_pkg::StepIdxW'(step_q);
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      schpt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = schpt_pkg::ST_MUL_SIN;
        end
      end
      schpt_pkg::ST_MUL_SIN: begin
        cmd_o.mul_en = 1'b1;
        state_d      = schpt_pkg::ST_MUL_COS;
      end
      schpt_pkg::ST_MUL_COS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_cos = 1'b1;
        cmd_o.sat_sin = 1'b1;
        state_d       = schpt_pkg::ST_SAT_COS;
      end
      schpt_pkg::ST_SAT_COS: begin
        cmd_o.sat_cos = 1'b1;
        state_d       = schpt_pkg::ST_PREP;
      end
      schpt_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = '0;
        state_d    = schpt_pkg::ST_ITER;
      end
      schpt_pkg::ST_ITER: begin
        cmd_o.iter = 1'b1;
        step_d     = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = schpt_pkg::ST_DONE;
        end
      end
      schpt_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = schpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = schpt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // An accepted transaction starts the multiply sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == schpt_pkg::ST_MUL_SIN)
    else $error("accepted transaction did not start the multiply");

  // The last CORDIC step leads to the result stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == schpt_pkg::ST_ITER && step_q == LastStep) |=> state_q == schpt_pkg::ST_DONE)
    else $error("CORDIC did not finish after the last step");

  // A result only appears from the result stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == schpt_pkg::ST_DONE)
    else $error("output valid raised outside the result stage");

  // A finished result waits while the previous one is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == schpt_pkg::ST_DONE && out_valid_q && out_stall_i)
      |=> state_q == schpt_pkg::ST_DONE)
    else $error("result overwrote a stalled transaction");

endmodule

`default_nettype wire

FILE: src/schpt_dp.sv
`default_nettype none

module schpt_dp #(
  parameter int unsigned ADC_BITS = schpt_pkg::AdcBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [schpt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [schpt_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic [ADC_BITS-1:0]              sin_sample_i,
  input  wire logic [ADC_BITS-1:0]              cos_sample_i,
  input  wire schpt_pkg::ctrl_cmd_t             cmd_i,
  output logic signed [schpt_pkg::HallW-1:0]    hall_sin_o,
  output logic signed [schpt_pkg::HallW-1:0]    hall_cos_o,
  output logic [schpt_pkg::AngleW-1:0]          raw_angle_o,
  output logic [schpt_pkg::AngleW-1:0]          phase_o,
  output logic [1:0]                            stroke_o,
  output logic [ADC_BITS-1:0]                   sin_min_o,
  output logic [ADC_BITS-1:0]                   sin_max_o,
  output logic [ADC_BITS-1:0]                   cos_min_o,
  output logic [ADC_BITS-1:0]                   cos_max_o
);

  localparam int unsigned DiffW = ADC_BITS + 1;
  localparam int unsigned GainSW = schpt_pkg::GainW + 1;
  localparam int unsigned ProdW = DiffW + GainSW;
  localparam int unsigned CW    = schpt_pkg::CordicW;
  localparam int unsigned ZW    = schpt_pkg::ZAccW;
  localparam int unsigned HW    = schpt_pkg::HallW;
  localparam int unsigned AW    = schpt_pkg::AngleW;

  // Configuration registers
  logic [ADC_BITS-1:0] sin_off_q, cos_off_q;
  logic [schpt_pkg::GainW-1:0] sin_gain_q, cos_gain_q;
  logic [AW-1:0] ang_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_off_q  <= ADC_BITS'(2048);
      cos_off_q  <= ADC_BITS'(2048);
      sin_gain_q <= 16'd2048;
      cos_gain_q <= 16'd2048;
      ang_off_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (schpt_pkg::cfg_reg_e'(cfg_idx_i))
        schpt_pkg::CFG_SIN_OFFSET:   sin_off_q  <= cfg_data_i[ADC_BITS-1:0];
        schpt_pkg::CFG_COS_OFFSET:   cos_off_q  <= cfg_data_i[ADC_BITS-1:0];
        schpt_pkg::CFG_SIN_GAIN:     sin_gain_q <= cfg_data_i;
        schpt_pkg::CFG_COS_GAIN:     cos_gain_q <= cfg_data_i;
        schpt_pkg::CFG_ANGLE_OFFSET: ang_off_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured samples
  logic [ADC_BITS-1:0] sin_smp_q, cos_smp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sin_smp_q <= sin_sample_i;
      cos_smp_q <= cos_sample_i;
    end
  end

  // Offset removal and gain, one channel per cycle through one multiplier
  logic signed [DiffW-1:0]  diff;
  logic signed [GainSW-1:0] gain;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [ProdW-1:0]  prod_sh;
  logic signed [HW-1:0]     sat_val;
  logic signed [HW-1:0]     hs_q, hc_q;

  always_comb begin
    if (cmd_i.mul_cos) begin
      diff = $signed({1'b0, cos_smp_q}) - $signed({1'b0, cos_off_q});
      gain = $signed({1'b0, cos_gain_q});
    end else begin
      diff = $signed({1'b0, sin_smp_q}) - $signed({1'b0, sin_off_q});
      gain = $signed({1'b0, sin_gain_q});
    end
  end

  // Drop the Q8.8 fraction (floor) and saturate to 16 bits
  always_comb begin
    prod_sh = prod_q >>> 8;
    if (prod_sh > ProdW'(32767)) begin
      sat_val = 16'sh7FFF;
    end else if (prod_sh < ProdW'(-32768)) begin
      sat_val = -16'sh8000;
    end else begin
      sat_val = prod_sh[HW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= diff * gain;
    end
    if (cmd_i.sat_sin) begin
      hs_q <= sat_val;
    end
    if (cmd_i.sat_cos) begin
      hc_q <= sat_val;
    end
  end

  // Vectoring CORDIC, one step per cycle
  logic signed [CW-1:0] x_q, y_q;
  logic signed [CW-1:0] x0, y0, dx, dy;
  logic [ZW-1:0]        z_q;
  logic                 zero_q;
  logic [ZW-1:0]        atan_val;

  assign x0       = $signed({{(CW-HW-16){hc_q[HW-1]}}, hc_q, 16'h0000});
  assign y0       = $signed({{(CW-HW-16){hs_q[HW-1]}}, hs_q, 16'h0000});
  assign dx       = y_q >>> cmd_i.step;
  assign dy       = x_q >>> cmd_i.step;
  assign atan_val = schpt_pkg::atan_entry(cmd_i.step);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      zero_q <= (hs_q == '0) && (hc_q == '0);
      // Fold the left half plane over by a half turn
      if (hc_q[HW-1]) begin
        x_q <= -x0;
        y_q <= -y0;
        z_q <= schpt_pkg::HalfTurnAcc;
      end else begin
        x_q <= x0;
        y_q <= y0;
        z_q <= '0;
      end
    end else if (cmd_i.iter) begin
      if (!y_q[CW-1]) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_val;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_val;
      end
    end
  end

  // Round the angle, derive phase and the stroke update
  logic [ZW-1:0]  z_rnd;
  logic [AW-1:0]  angle;
  logic [AW-1:0]  phase;
  logic           in_quarter, past_quarter;
  logic [1:0]     stroke_q, stroke_d;

  assign z_rnd        = z_q + schpt_pkg::RoundHalf;
  assign angle        = zero_q ? '0 : z_rnd[ZW-1:ZW-AW];
  assign phase        = ang_off_q - angle;
  assign in_quarter   = (phase < schpt_pkg::QuarterTurn)
                     || (phase > schpt_pkg::ThreeQuarterTurn);
  assign past_quarter = (phase > schpt_pkg::QuarterTurn)
                     && (phase < schpt_pkg::ThreeQuarterTurn);

  always_comb begin
    stroke_d = stroke_q;
    case (schpt_pkg::stroke_e'(stroke_q))
      schpt_pkg::STROKE_DOWN: begin
        if (past_quarter) stroke_d = schpt_pkg::STROKE_UP;
      end
      schpt_pkg::STROKE_UP: begin
        if (in_quarter) stroke_d = schpt_pkg::STROKE_DOWN;
      end
      default: begin
        stroke_d = in_quarter ? schpt_pkg::STROKE_DOWN : schpt_pkg::STROKE_UP;
      end
    endcase
  end

  // Tracker state: stroke and raw code range, advanced with each result
  logic [ADC_BITS-1:0] sin_lo_q, sin_hi_q, cos_lo_q, cos_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stroke_q <= schpt_pkg::STROKE_UNKNOWN;
      sin_lo_q <= '1;
      sin_hi_q <= '0;
      cos_lo_q <= '1;
      cos_hi_q <= '0;
    end else if (cmd_i.load) begin
      stroke_q <= stroke_d;
      if (sin_smp_q < sin_lo_q) sin_lo_q <= sin_smp_q;
      if (sin_smp_q > sin_hi_q) sin_hi_q <= sin_smp_q;
      if (cos_smp_q < cos_lo_q) cos_lo_q <= cos_smp_q;
      if (cos_smp_q > cos_hi_q) cos_hi_q <= cos_smp_q;
    end
  end

  // Output register
  logic signed [HW-1:0] hall_sin_q, hall_cos_q;
  logic [AW-1:0]        raw_angle_q, phase_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hall_sin_q  <= hs_q;
      hall_cos_q  <= hc_q;
      raw_angle_q <= angle;
      phase_q     <= phase;
    end
  end

  assign hall_sin_o  = hall_sin_q;
  assign hall_cos_o  = hall_cos_q;
  assign raw_angle_o = raw_angle_q;
  assign phase_o     = phase_q;
  assign stroke_o    = stroke_q;
  assign sin_min_o   = sin_lo_q;
  assign sin_max_o   = sin_hi_q;
  assign cos_min_o   = cos_lo_q;
  assign cos_max_o   = cos_hi_q;

endmodule

`default_nettype wire

FILE: sim/phase_report_checker.sv
module phase_report_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [schpt_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [schpt_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [schpt_pkg::AdcBitsDef-1:0]     sin_sample_i,
  input  logic [schpt_pkg::AdcBitsDef-1:0]     cos_sample_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [schpt_pkg::HallW-1:0]   hall_sin_i,
  input  logic signed [schpt_pkg::HallW-1:0]   hall_cos_i,
  input  logic [schpt_pkg::AngleW-1:0]         raw_angle_i,
  input  logic [schpt_pkg::AngleW-1:0]         phase_i,
  input  logic [1:0]                           stroke_i,
  input  logic [schpt_pkg::AdcBitsDef-1:0]     sin_min_i,
  input  logic [schpt_pkg::AdcBitsDef-1:0]     sin_max_i,
  input  logic [schpt_pkg::AdcBitsDef-1:0]     cos_min_i,
  input  logic [schpt_pkg::AdcBitsDef-1:0]     cos_max_i,
  output int                                   mismatches_o,
  output int                                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: track the register writes, predict one phase report per
  // accepted sample pair and compare every accepted report against the
  // oldest prediction still awaited.

  localparam int unsigned CodeW   = schpt_pkg::AdcBitsDef;
  localparam int unsigned HallW   = schpt_pkg::HallW;
  localparam int unsigned AngleW  = schpt_pkg::AngleW;
  localparam int unsigned ZAccW   = schpt_pkg::ZAccW;
  localparam int unsigned GainW   = schpt_pkg::GainW;
  localparam int unsigned NumIter = schpt_pkg::CordicStepsDef;
  localparam int          ReportLimit = 10;

  // Arctangent of 2^-i as a fraction of a turn scaled by 2^32
  localparam logic [ZAccW-1:0] ArctanStep [schpt_pkg::MaxSteps] = '{
    32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
  };

  typedef struct {
    logic signed [HallW-1:0] sin_corr;
    logic signed [HallW-1:0] cos_corr;
    logic [AngleW-1:0]       raw_angle;
    logic [AngleW-1:0]       phase;
    schpt_pkg::stroke_e      stroke;
    logic [CodeW-1:0]        sin_min;
    logic [CodeW-1:0]        sin_max;
    logic [CodeW-1:0]        cos_min;
    logic [CodeW-1:0]        cos_max;
  } phase_report_t;

  // Shadow registers and tracker state
  logic [CodeW-1:0]   sin_zero, cos_zero;
  logic [GainW-1:0]   sin_scale, cos_scale;
  logic [AngleW-1:0]  zero_phase;
  schpt_pkg::stroke_e direction;
  logic [CodeW-1:0]   sin_lo, sin_hi, cos_lo, cos_hi;

  phase_report_t awaited_reports [$];
  int            mismatch_cnt;

  // Remove the zero point, apply the Q8.8 gain, saturate to 16 bits
  function automatic logic signed [HallW-1:0] corrected_hall(
    input logic [CodeW-1:0] code,
    input logic [CodeW-1:0] zero,
    input logic [GainW-1:0] gain
  );
    longint prod;
    prod = ((longint'(code) - longint'(zero)) * longint'(gain)) >>> 8;
    if (prod > 32767) prod = 32767;
    if (prod < -32768) prod = -32768;
    return prod[HallW-1:0];
  endfunction

  // Vectoring CORDIC atan2 as a 16-bit binary angle
  function automatic logic [AngleW-1:0] cordic_angle(
    input logic signed [HallW-1:0] ys,
    input logic signed [HallW-1:0] xs
  );
    longint           x, y, dx, dy;
    logic [ZAccW-1:0] z, zr;
    if (xs == 0 && ys == 0) return '0;
    x = longint'(xs) * 65536;
    y = longint'(ys) * 65536;
    z = '0;
    // Fold the left half plane over by a half turn
    if (x < 0) begin
      x = -x;
      y = -y;
      z = schpt_pkg::HalfTurnAcc;
    end
    for (int i = 0; i < NumIter; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ArctanStep[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ArctanStep[i];
      end
    end
    zr = z + schpt_pkg::RoundHalf;
    return zr[ZAccW-1:ZAccW-AngleW];
  endfunction

  // Work out the report for one sample pair and advance the tracker state
  function automatic phase_report_t predict_report(
    input logic [CodeW-1:0] s,
    input logic [CodeW-1:0] c
  );
    phase_report_t            r;
    logic signed [AngleW-1:0] signed_phase;
    int                       mag;
    int                       quarter;
    quarter     = int'(schpt_pkg::QuarterTurn);
    r.sin_corr  = corrected_hall(s, sin_zero, sin_scale);
    r.cos_corr  = corrected_hall(c, cos_zero, cos_scale);
    r.raw_angle = cordic_angle(r.sin_corr, r.cos_corr);
    r.phase     = zero_phase - r.raw_angle;
    signed_phase = r.phase;
    mag = (signed_phase < 0) ? -int'(signed_phase) : int'(signed_phase);
    // Quarter-turn test; exactly a quarter turn holds a known direction
    case (direction)
      schpt_pkg::STROKE_DOWN: if (mag > quarter) direction = schpt_pkg::STROKE_UP;
      schpt_pkg::STROKE_UP:   if (mag < quarter) direction = schpt_pkg::STROKE_DOWN;
      default: direction = (mag < quarter) ? schpt_pkg::STROKE_DOWN : schpt_pkg::STROKE_UP;
    endcase
    if (s > sin_hi) sin_hi = s;
    if (s < sin_lo) sin_lo = s;
    if (c > cos_hi) cos_hi = c;
    if (c < cos_lo) cos_lo = c;
    r.stroke  = direction;
    r.sin_min = sin_lo;
    r.sin_max = sin_hi;
    r.cos_min = cos_lo;
    r.cos_max = cos_hi;
    return r;
  endfunction

  task automatic note_field(input string field, input longint want, input longint got);
    mismatch_cnt++;
    if (mismatch_cnt <= ReportLimit)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    phase_report_t want;
    if (!rst_ni) begin
      sin_zero   <= 12'd2048;
      cos_zero   <= 12'd2048;
      sin_scale  <= 16'd2048;
      cos_scale  <= 16'd2048;
      zero_phase <= '0;
      direction  = schpt_pkg::STROKE_UNKNOWN;
      sin_lo     = '1;
      sin_hi     = '0;
      cos_lo     = '1;
      cos_hi     = '0;
      awaited_reports.delete();
      pending_o  <= 0;
    end else begin
      // Compare a delivered report against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (awaited_reports.size() == 0) begin
          note_field("unexpected report", 0, 1);
        end else begin
          want = awaited_reports.pop_front();
          if (hall_sin_i !== want.sin_corr)
            note_field("hall_sin_o", want.sin_corr, hall_sin_i);
          if (hall_cos_i !== want.cos_corr)
            note_field("hall_cos_o", want.cos_corr, hall_cos_i);
          if (raw_angle_i !== want.raw_angle)
            note_field("raw_angle", want.raw_angle, raw_angle_i);
          if (phase_i !== want.phase)
            note_field("phase", want.phase, phase_i);
          if (stroke_i !== want.stroke)
            note_field("stroke", want.stroke, stroke_i);
          if (sin_min_i !== want.sin_min)
            note_field("sin_min", want.sin_min, sin_min_i);
          if (sin_max_i !== want.sin_max)
            note_field("sin_max", want.sin_max, sin_max_i);
          if (cos_min_i !== want.cos_min)
            note_field("cos_min", want.cos_min, cos_min_i);
          if (cos_max_i !== want.cos_max)
            note_field("cos_max", want.cos_max, cos_max_i);
        end
      end
      // Predict on every accepted sample pair
      if (in_valid_i && !in_stall_i)
        awaited_reports.push_back(predict_report(sin_sample_i, cos_sample_i));
      // Track register writes; unknown indexes drop out
      if (cfg_we_i) begin
        case (cfg_idx_i)
          schpt_pkg::CFG_SIN_OFFSET:   sin_zero   <= cfg_data_i[CodeW-1:0];
          schpt_pkg::CFG_COS_OFFSET:   cos_zero   <= cfg_data_i[CodeW-1:0];
          schpt_pkg::CFG_SIN_GAIN:     sin_scale  <= cfg_data_i;
          schpt_pkg::CFG_COS_GAIN:     cos_scale  <= cfg_data_i;
          schpt_pkg::CFG_ANGLE_OFFSET: zero_phase <= cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= awaited_reports.size();
    end
  end

  always_comb mismatches_o = mismatch_cnt;

  initial mismatch_cnt = 0;

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CodeW        = schpt_pkg::AdcBitsDef;
  localparam int unsigned CfgIdxW      = schpt_pkg::CfgIdxW;
  localparam int unsigned CfgDataW     = schpt_pkg::CfgDataW;
  localparam int unsigned HallW        = schpt_pkg::HallW;
  localparam int unsigned AngleW       = schpt_pkg::AngleW;
  localparam int          LimitCycles  = 500000;
  localparam int          SettleCycles = 40;
  localparam int          PhaseItems   = 235;
  localparam int          NumPhases    = 7;
  localparam int          HoldCycles   = 400;
  localparam int          HoldAfter    = 500;
  localparam int          CalmPhase    = 3;
  localparam logic [CfgIdxW-1:0] CfgIdxTop = '1;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx = '0;
  logic [CfgDataW-1:0]   cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CodeW-1:0]      sin_sample = '0;
  logic [CodeW-1:0]      cos_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [HallW-1:0] sin_corr, cos_corr;
  logic [AngleW-1:0]     raw_angle, phase;
  logic [1:0]            stroke;
  logic [CodeW-1:0]      sin_min, sin_max, cos_min, cos_max;

  int mismatches;
  int pending;
  int cycle_cnt = 0;
  int sent_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit calm = 1'b0;

  // Offsets in force, used to aim samples around the zero point
  logic [CodeW-1:0] cur_sin_zero = 12'd2048;
  logic [CodeW-1:0] cur_cos_zero = 12'd2048;

  sincos_hall_phase_tracker_core DUT (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sin_sample_i (sin_sample),
    .cos_sample_i (cos_sample),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .hall_sin_o   (sin_corr),
    .hall_cos_o   (cos_corr),
    .raw_angle_o  (raw_angle),
    .phase_o      (phase),
    .stroke_o     (stroke),
    .sin_min_o    (sin_min),
    .sin_max_o    (sin_max),
    .cos_min_o    (cos_min),
    .cos_max_o    (cos_max)
  );

  phase_report_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .sin_sample_i (sin_sample),
    .cos_sample_i (cos_sample),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .hall_sin_i   (sin_corr),
    .hall_cos_i   (cos_corr),
    .raw_angle_i  (raw_angle),
    .phase_i      (phase),
    .stroke_i     (stroke),
    .sin_min_i    (sin_min),
    .sin_max_i    (sin_max),
    .cos_min_i    (cos_min),
    .cos_max_i    (cos_max),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stall, one long hold-off once the run is under way
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_cnt >= HoldAfter) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 25);
    end
  end

  // Offer one sample pair and hold it until accepted
  task automatic send_pair(input logic [CodeW-1:0] s, input logic [CodeW-1:0] c);
    int gap;
    gap = (!calm && $urandom_range(99) < 25) ? $urandom_range(6, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    sin_sample <= s;
    cos_sample <= c;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
  endtask

  // Drop valid and wait until every report is in and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CfgDataW-1:0];
    @(posedge clk);
  endtask

  // Write all five registers plus one index past the end of the map
  task automatic load_settings(
    input logic [31:0] s_zero, input logic [31:0] c_zero,
    input logic [31:0] s_gain, input logic [31:0] c_gain,
    input logic [31:0] ang
  );
    write_reg(schpt_pkg::CFG_SIN_OFFSET, s_zero);
    write_reg(schpt_pkg::CFG_COS_OFFSET, c_zero);
    write_reg(schpt_pkg::CFG_SIN_GAIN, s_gain);
    write_reg(schpt_pkg::CFG_COS_GAIN, c_gain);
    write_reg(schpt_pkg::CFG_ANGLE_OFFSET, ang);
    write_reg(CfgIdxW'($urandom_range(CfgIdxTop, schpt_pkg::CFG_ANGLE_OFFSET + 1)),
              $urandom);
    cfg_we <= 1'b0;
    cur_sin_zero = s_zero[CodeW-1:0];
    cur_cos_zero = c_zero[CodeW-1:0];
  endtask

  // Mostly uniform codes, some close to the zero point, a few at the rails
  function automatic logic [CodeW-1:0] pick_code(input logic [CodeW-1:0] zero);
    int k, v;
    k = $urandom_range(99);
    if (k < 55)
      v = $urandom_range(4095);
    else if (k < 80)
      v = int'(zero) + int'($urandom_range(128)) - 64;
    else if (k < 92)
      v = int'(zero) + int'($urandom_range(1200)) - 600;
    else begin
      case ($urandom_range(2))
        0:       v = 0;
        1:       v = 4095;
        default: v = int'(zero);
      endcase
    end
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[CodeW-1:0];
  endfunction

  task automatic realistic_settings();
    load_settings(2048 + $urandom_range(600) - 300, 2048 + $urandom_range(600) - 300,
                  $urandom_range(4096, 256), $urandom_range(4096, 256), $urandom_range(65535));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Reset settings: zero vector, rails, axes, quarter turns, tiny vectors
    send_pair(12'd2048, 12'd2048);
    send_pair(12'd4095, 12'd4095);
    send_pair(12'd0, 12'd0);
    send_pair(12'd4095, 12'd0);
    send_pair(12'd0, 12'd4095);
    send_pair(12'd2048, 12'd3000);
    send_pair(12'd2048, 12'd1000);
    send_pair(12'd3000, 12'd2048);
    send_pair(12'd1000, 12'd2048);
    send_pair(12'd2049, 12'd2048);
    send_pair(12'd2047, 12'd2047);
    settle();

    // Zero gains force the zero vector; full angle offset
    load_settings(0, 4095, 0, 0, 65535);
    send_pair(12'd4095, 12'd0);
    send_pair(12'd1234, 12'd3210);
    settle();

    // Largest gains at the offset rails; the first pair saturates both channels
    load_settings(4095, 0, 65535, 65535, 0);
    send_pair(12'd0, 12'd4095);
    send_pair(12'd4095, 12'd0);
    send_pair(12'd4094, 12'd1);
    settle();

    // Unit gain, quarter-turn offset: cosine-axis phases land on a quarter turn
    load_settings(2048, 2048, 256, 256, 16384);
    send_pair(12'd2048, 12'd2148);
    send_pair(12'd2048, 12'd1948);
    send_pair(12'd2148, 12'd2048);
    settle();

    // Random phases over a spread of settings
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        1:         load_settings(0, 0, 65535, 65535, 65535);
        2:         load_settings(4095, 4095, 0, 65535, 0);
        CalmPhase: load_settings($urandom, $urandom, $urandom, $urandom, $urandom);
        5:         load_settings(2048, 2048, 256, 256, 0);
        default:   realistic_settings();
      endcase
      calm = (p == CalmPhase);
      for (int n = 0; n < PhaseItems; n++)
        send_pair(pick_code(cur_sin_zero), pick_code(cur_cos_zero));
      settle();
    end
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/schpt_pkg.sv
src/schpt_ctrl.sv
src/schpt_dp.sv
src/sincos_hall_phase_tracker_core.sv
sim/phase_report_checker.sv
sim/tb_top.sv
